// ===== rtl/itdp_pkg.sv =====
// ----------------------------------------------------------------------------
// itdp_pkg: shared types and constants of the decimal integer formatter
// Payload structs, register indexes, ASCII codes and the divide-by-ten factor.
// ----------------------------------------------------------------------------
`default_nettype none

package itdp_pkg;

	localparam int MAX_PRECISION_DEF = 63;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int PREC_W     = 6;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 10;
	localparam int ND_W       = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRECISION_COUNT = 2'd0,
		REG_PRECISION_GIVEN = 2'd1,
		REG_PLUS_FLAG       = 2'd2,
		REG_BLANK_FLAG      = 2'd3
	} reg_idx_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_BLANK = 8'h20;

	// ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == x / 10 for all 32-bit x
	localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef struct packed {
		logic [31:0] value;
		logic        signed_mode;
	} in_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_sign;
		logic       show_sign;
		logic       last;
	} out_t;

endpackage

`default_nettype wire

// ===== rtl/itdp_div10.sv =====
// ----------------------------------------------------------------------------
// itdp_div10: shared divide-by-ten step
// Registers the quotient of a load by reciprocal multiply; the remainder is
// formed from the held dividend in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itdp_div10
	import itdp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               load,
	input  wire logic [31:0]        dividend,
	output logic      [31:0]        quot,
	output logic      [DIGIT_W-1:0] rem
);

	logic [63:0] prod;
	logic [31:0] dividend_q;
	logic [31:0] quot_q;
	logic [31:0] quot_x10;
	logic [31:0] diff;

	assign prod = {32'd0, dividend} * {32'd0, RECIP10};

	always_ff @(posedge clk) begin
		if (load) begin
			dividend_q <= dividend;
			quot_q     <= {3'd0, prod[63:RECIP_SHIFT]};
		end
	end

	// q*10 as a shift-add
	assign quot_x10 = {quot_q[28:0], 3'd0} + {quot_q[30:0], 1'b0};
	assign diff     = dividend_q - quot_x10;
	assign quot     = quot_q;
	assign rem      = diff[DIGIT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/int_to_decimal_precision_format_unit.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_precision_format_unit: printf-style decimal integer formatter
// Converts one 32-bit value to a sign result followed by decimal digits, if any.
//
// Usage:
//   in channel : in_data (value, signed_mode) moves on a transfer when
//                in_valid is high and in_stall is low. in_stall stays high
//                from the transfer until the last result has been loaded.
//   out channel: one result per transfer (char_code, is_sign, show_sign,
//                last). The first result of a run is the sign; the last is
//                marked. out_data is held while out_stall is high.
//   cfg port   : cfg_we/cfg_index/cfg_data, write only while idle.
//   Timing     : digit extraction runs through one shared divide-by-ten
//                unit, a divide state then a remainder state per digit (nd
//                digits, 1 to 10). The sign is loaded next, then
//                max(precision, nd) digits, one digit per cycle while the
//                receiver does not stall. A stall holds the output
//                register and the sequencer waits.
//   Reset      : arst_n returns the sequencer to idle and clears the output
//                valid and all configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_precision_format_unit
	import itdp_pkg::*;
#(
	parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// position counter width: covers the saturated precision, and ten digits when MAX_PRECISION is 8 or more
	localparam int CW = $clog2(MAX_PRECISION + 1);
	// compare width for saturating the precision register
	localparam int SW = (CW > PREC_W) ? CW : PREC_W;
	localparam logic [SW-1:0] MAX_PREC_S = SW'(MAX_PRECISION);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_REM  = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_DIGS = 5'b10000
	} state_t;

	state_t state_q;

	// configuration
	logic [PREC_W-1:0] precision_count_q;
	logic              precision_given_q;
	logic              plus_flag_q;
	logic              blank_flag_q;

	// per-item working registers
	logic [31:0]        mag_q;
	logic [7:0]         sign_ch_q;
	logic               show_q;
	logic               zero_case_q;
	logic [ND_W-1:0]    nd_q;
	logic [DIGIT_W-1:0] digs_q [MAX_DIGITS];
	logic [CW-1:0]      pos_q;

	logic               out_valid_q;
	out_t               out_q;

	logic               in_xfer;
	logic               can_load;
	logic               neg;
	logic [31:0]        quot;
	logic [DIGIT_W-1:0] rem;
	logic [SW-1:0]      prec_ext;
	logic [SW-1:0]      prec_sat;
	logic [SW-1:0]      nd_ext;
	logic [SW-1:0]      total;
	logic [CW-1:0]      nd_cw;
	logic [DIGIT_W-1:0] cur_digit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign neg = in_data.signed_mode && in_data.value[31];

	// shared divide-by-ten unit
	itdp_div10 u_div10 (
		.clk      (clk),
		.load     (state_q == ST_DIV),
		.dividend (mag_q),
		.quot     (quot),
		.rem      (rem)
	);

	// run length: precision clipped to the maximum, never below the digit count
	assign prec_ext = SW'(precision_count_q);
	assign prec_sat = (prec_ext > MAX_PREC_S) ? MAX_PREC_S : prec_ext;
	assign nd_ext   = SW'(nd_q);
	assign total    = (prec_sat > nd_ext) ? prec_sat : nd_ext;

	// padding zeros above the extracted digits
	assign nd_cw     = CW'(nd_q);
	assign cur_digit = (pos_q < nd_cw) ? digs_q[pos_q[ND_W-1:0]] : '0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_count_q <= '0;
			precision_given_q <= 1'b0;
			plus_flag_q       <= 1'b0;
			blank_flag_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PRECISION_COUNT: precision_count_q <= cfg_data[PREC_W-1:0];
				REG_PRECISION_GIVEN: precision_given_q <= cfg_data[0];
				REG_PLUS_FLAG:       plus_flag_q       <= cfg_data[0];
				REG_BLANK_FLAG:      blank_flag_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// drop the output once it has been taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						// an explicit zero precision on a zero value skips the digits
						if (in_data.value == 32'd0 && precision_given_q &&
							precision_count_q == '0) begin
							state_q <= ST_SIGN;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					if (quot == 32'd0 || nd_q == ND_W'(MAX_DIGITS - 1)) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_SIGN: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						state_q     <= zero_case_q ? ST_IDLE : ST_DIGS;
					end
				end
				ST_DIGS: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						if (pos_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					mag_q <= neg ? (32'd0 - in_data.value) : in_data.value;
					if (neg) begin
						sign_ch_q <= CH_MINUS;
					end else if (in_data.signed_mode && blank_flag_q && !plus_flag_q) begin
						sign_ch_q <= CH_BLANK;
					end else begin
						sign_ch_q <= CH_PLUS;
					end
					show_q      <= in_data.signed_mode && (neg || plus_flag_q || blank_flag_q);
					zero_case_q <= (in_data.value == 32'd0) && precision_given_q &&
						(precision_count_q == '0);
					nd_q        <= '0;
				end
			end
			ST_DIV: ;
			ST_REM: begin
				// store the next digit, least significant first
				digs_q[nd_q] <= rem;
				nd_q         <= nd_q + ND_W'(1);
				mag_q        <= quot;
			end
			ST_SIGN: begin
				if (can_load) begin
					out_q.char_code <= sign_ch_q;
					out_q.is_sign   <= 1'b1;
					out_q.show_sign <= show_q;
					out_q.last      <= zero_case_q;
					pos_q           <= CW'(total - SW'(1));
				end
			end
			ST_DIGS: begin
				if (can_load) begin
					out_q.char_code <= CH_ZERO + {4'd0, cur_digit};
					out_q.is_sign   <= 1'b0;
					out_q.show_sign <= 1'b0;
					out_q.last      <= (pos_q == '0);
					pos_q           <= pos_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	// no new item is taken until the run is finished
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while a run is in progress");

	// digit extraction never exceeds ten digits
	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REM) |-> (nd_q < ND_W'(MAX_DIGITS)))
		else $error("digit store overrun");

	// a sign result carries one of the three sign characters
	a_sign_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.is_sign) |->
		(out_data.char_code == CH_MINUS || out_data.char_code == CH_PLUS ||
		 out_data.char_code == CH_BLANK))
		else $error("bad sign character");

	// a digit result is a decimal digit with no sign shown
	a_digit_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.is_sign) |->
		(out_data.char_code >= CH_ZERO && out_data.char_code <= CH_NINE &&
		 !out_data.show_sign))
		else $error("bad digit result");
`endif

endmodule

`default_nettype wire
